// File: rtl/aac_llf_pkg.sv
package aac_llf_pkg;

  localparam int MAX_AU_BYTES_DEF = 4095;
  localparam int QDEPTH = 4;
  localparam int QPTR_W = $clog2(QDEPTH);

  localparam logic KIND_HDR = 1'b0;
  localparam logic KIND_PAY = 1'b1;

  localparam logic [10:0] SYNC_WORD = 11'h2B7;
  localparam logic [7:0] MUX_CFG_BYTE = 8'b0010_0000;
  localparam logic [4:0] AOT_SBR = 5'b00101;
  localparam logic [4:0] AOT_LC = 5'b00010;
  localparam logic [7:0] SBR_TAIL = 8'h0F;
  localparam logic [7:0] SBR_FREE = 8'hF0;
  localparam logic [7:0] LC_TAIL = 8'h1F;
  localparam logic [7:0] LC_FREE = 8'hE0;
  localparam logic [7:0] FULL_BYTE = 8'hFF;
  localparam logic [7:0] LEN_STEP = 8'd255;

  typedef struct packed {
    logic        is_hdr;
    logic        close;
    logic        sbr;
    logic        rate;
    logic        ch_mode;
    logic        au_zero;
    logic [4:0]  n255;
    logic [7:0]  rem;
    logic [12:0] len;
    logic [7:0]  data;
    logic        last;
  } cmd_t;

  function automatic logic [7:0] hdr_byte(input logic [3:0] i, input logic sbr,
                                           input logic rate, input logic ch_mode,
                                           input logic [12:0] len);
    logic [3:0] idx;
    logic [2:0] ext;
    logic [3:0] ch;
    logic [7:0] b;
    idx = sbr ? (rate ? 4'h6 : 4'h8) : (rate ? 4'h3 : 4'h5);
    ext = rate ? 3'd3 : 3'd5;
    ch = {3'b000, ch_mode} + 4'd1;
    case (i)
      4'd0: b = SYNC_WORD[10:3];
      4'd1: b = {SYNC_WORD[2:0], len[12:8]};
      4'd2: b = len[7:0];
      4'd3: b = MUX_CFG_BYTE;
      4'd4: b = 8'h00;
      4'd5: b = {sbr ? AOT_SBR : AOT_LC, idx[3:1]};
      4'd6: b = {idx[0], ch, sbr ? {1'b0, ext[2:1]} : 3'b100};
      4'd7: b = sbr ? {ext[0], 7'b000_1010} : LC_TAIL;
      4'd8: b = SBR_TAIL;
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

// File: rtl/aac_llf_if.sv
interface aac_llf_in_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [11:0] au_length;
  logic        rate_flag;
  logic        sbr_on;
  logic        channel_mode;
  logic [7:0]  payload_byte;
  logic        payload_last;

  modport source(output valid, kind, au_length, rate_flag, sbr_on, channel_mode,
                 payload_byte, payload_last, input ready);
  modport sink(input valid, kind, au_length, rate_flag, sbr_on, channel_mode,
               payload_byte, payload_last, output ready);
endinterface

interface aac_llf_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       frame_end;

  modport source(output valid, out_byte, frame_end, input ready);
  modport sink(input valid, out_byte, frame_end, output ready);
endinterface

// File: rtl/aac_llf_front.sv
module aac_llf_front #(
  parameter int MAX_AU_BYTES = 4095
) (
  input  logic               clk,
  input  logic               rst_n,
  aac_llf_in_if.sink         in_ch,
  input  logic               q_full,
  output logic               push,
  output aac_llf_pkg::cmd_t  push_cmd
);
  import aac_llf_pkg::*;

  localparam logic [12:0] MaxAu = 13'(MAX_AU_BYTES);

  logic        open_r, open_nxt;
  logic        acc;
  logic [11:0] au;
  logic [12:0] sum;
  logic [4:0]  n255;
  logic [11:0] mult;
  logic [11:0] rem;

  assign in_ch.ready = !q_full;
  assign acc = in_ch.valid && !q_full;

  always_comb begin
    au = ({1'b0, in_ch.au_length} > MaxAu) ? MaxAu[11:0] : in_ch.au_length;
    sum = {1'b0, au} + 13'd1 + {9'd0, au[11:8]};
    n255 = sum[12:8];
    mult = {n255[3:0], 8'd0} - {7'd0, n255};
    rem = au - mult;
  end

  always_comb begin
    push_cmd.is_hdr = (in_ch.kind == KIND_HDR);
    push_cmd.close = open_r;
    push_cmd.sbr = in_ch.sbr_on;
    push_cmd.rate = in_ch.rate_flag;
    push_cmd.ch_mode = in_ch.channel_mode;
    push_cmd.au_zero = (au == 12'd0);
    push_cmd.n255 = n255;
    push_cmd.rem = rem[7:0];
    push_cmd.len = {1'b0, au} + {8'd0, n255} + {12'd0, in_ch.sbr_on} + 13'd7;
    push_cmd.data = in_ch.payload_byte;
    push_cmd.last = in_ch.payload_last;
  end

  always_comb begin
    push = 1'b0;
    open_nxt = open_r;
    if (acc) begin
      if (in_ch.kind == KIND_HDR) begin
        push = 1'b1;
        open_nxt = (au != 12'd0);
      end else if (open_r) begin
        push = 1'b1;
        if (in_ch.payload_last) begin
          open_nxt = 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      open_r <= 1'b0;
    end else begin
      open_r <= open_nxt;
    end
  end

endmodule

// File: rtl/aac_llf_queue.sv
module aac_llf_queue (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  aac_llf_pkg::cmd_t  push_cmd,
  output logic               full,
  input  logic               pop,
  output logic               q_valid,
  output aac_llf_pkg::cmd_t  q_cmd
);
  import aac_llf_pkg::*;

  cmd_t            mem_r [QDEPTH];
  logic [QPTR_W-1:0] wp_r, wp_nxt, rp_r, rp_nxt;
  logic [QPTR_W:0]   cnt_r, cnt_nxt;

  assign full = (cnt_r == (QPTR_W + 1)'(QDEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_cmd = mem_r[rp_r];

  always_comb begin
    wp_nxt = push ? wp_r + 1'b1 : wp_r;
    rp_nxt = pop ? rp_r + 1'b1 : rp_r;
    cnt_nxt = cnt_r + (QPTR_W + 1)'(push) - (QPTR_W + 1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      wp_r <= wp_nxt;
      rp_r <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

// File: rtl/aac_llf_back.sv
module aac_llf_back (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               q_valid,
  input  aac_llf_pkg::cmd_t  q_cmd,
  output logic               pop,
  aac_llf_out_if.source      out_ch
);
  import aac_llf_pkg::*;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_CLOSE = 3'd1;
  localparam logic [2:0] PH_HDR = 3'd2;
  localparam logic [2:0] PH_FF = 3'd3;
  localparam logic [2:0] PH_REM = 3'd4;
  localparam logic [2:0] PH_FLUSH = 3'd5;

  logic [2:0] phase_r, phase_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  cmd_t       cmd_r, cmd_nxt;
  logic [7:0] carry_r, carry_nxt;
  logic       six_r, six_nxt;
  logic       ov_r, ov_nxt;
  logic [7:0] ob_r, ob_nxt;
  logic       fe_r, fe_nxt;
  logic       adv;
  logic       emit;
  logic [7:0] eb;
  logic       ef;

  function automatic logic [7:0] shr(input logic six, input logic [7:0] b);
    return six ? (b >> 6) : (b >> 5);
  endfunction

  function automatic logic [7:0] shl(input logic six, input logic [7:0] b);
    return six ? (b << 2) : (b << 3);
  endfunction

  assign adv = !ov_r || out_ch.ready;
  assign out_ch.valid = ov_r;
  assign out_ch.out_byte = ob_r;
  assign out_ch.frame_end = fe_r;

  always_comb begin
    phase_nxt = phase_r;
    cnt_nxt = cnt_r;
    cmd_nxt = cmd_r;
    carry_nxt = carry_r;
    six_nxt = six_r;
    pop = 1'b0;
    emit = 1'b0;
    eb = 8'h00;
    ef = 1'b0;
    if (adv) begin
      case (phase_r)
        PH_IDLE: begin
          if (q_valid) begin
            pop = 1'b1;
            cmd_nxt = q_cmd;
            cnt_nxt = '0;
            if (q_cmd.is_hdr) begin
              phase_nxt = q_cmd.close ? PH_CLOSE : PH_HDR;
            end else begin
              emit = 1'b1;
              eb = carry_r | shr(six_r, q_cmd.data);
              carry_nxt = shl(six_r, q_cmd.data);
              if (q_cmd.last) begin
                phase_nxt = PH_FLUSH;
              end
            end
          end
        end
        PH_CLOSE: begin
          emit = 1'b1;
          eb = carry_r;
          ef = 1'b1;
          phase_nxt = PH_HDR;
        end
        PH_HDR: begin
          emit = 1'b1;
          eb = hdr_byte(cnt_r[3:0], cmd_r.sbr, cmd_r.rate, cmd_r.ch_mode, cmd_r.len);
          if (cnt_r == (cmd_r.sbr ? 5'd8 : 5'd7)) begin
            carry_nxt = cmd_r.sbr ? SBR_FREE : LC_FREE;
            six_nxt = cmd_r.sbr;
            cnt_nxt = '0;
            phase_nxt = (cmd_r.n255 != 5'd0) ? PH_FF : PH_REM;
          end else begin
            cnt_nxt = cnt_r + 5'd1;
          end
        end
        PH_FF: begin
          emit = 1'b1;
          eb = carry_r | shr(six_r, FULL_BYTE);
          carry_nxt = shl(six_r, FULL_BYTE);
          cnt_nxt = cnt_r + 5'd1;
          if (cnt_nxt == cmd_r.n255) begin
            phase_nxt = PH_REM;
          end
        end
        PH_REM: begin
          emit = 1'b1;
          eb = carry_r | shr(six_r, cmd_r.rem);
          carry_nxt = shl(six_r, cmd_r.rem);
          phase_nxt = cmd_r.au_zero ? PH_FLUSH : PH_IDLE;
        end
        PH_FLUSH: begin
          emit = 1'b1;
          eb = carry_r;
          ef = 1'b1;
          phase_nxt = PH_IDLE;
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
  end

  always_comb begin
    ov_nxt = ov_r;
    ob_nxt = ob_r;
    fe_nxt = fe_r;
    if (emit) begin
      ov_nxt = 1'b1;
      ob_nxt = eb;
      fe_nxt = ef;
    end else if (out_ch.ready) begin
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      cnt_r <= '0;
      carry_r <= 8'h00;
      six_r <= 1'b0;
      ov_r <= 1'b0;
    end else begin
      phase_r <= phase_nxt;
      cnt_r <= cnt_nxt;
      carry_r <= carry_nxt;
      six_r <= six_nxt;
      ov_r <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    ob_r <= ob_nxt;
    fe_r <= fe_nxt;
  end

endmodule

// File: rtl/aac_loas_latm_framer_unit.sv
// LOAS/LATM framer: wraps each AAC access unit in an AudioSyncStream frame.
// in_ch carries header items (kind 0: length, rate, SBR, channel mode) and
// payload byte items (kind 1); out_ch carries the framed byte stream, with
// frame_end set on the last byte of each frame. Both are valid/ready
// channels; a transfer happens on a clock edge with valid and ready high.
// The front end classifies items and works out the length fields, then
// places them in a four-entry command queue; the back end's sequencer
// drives the output register. A payload byte goes through a queue entry and
// then the output register; bytes pass at one per cycle while the receiver
// takes them, and a unit's last byte is followed by a flush byte. A header
// yields a close byte if a frame is open, the header and the length bytes.
// in_ch.ready falls only while the queue is full. When the receiver stalls,
// the held byte stays on out_ch and the queue keeps taking items until it
// fills. Synchronous reset empties the queue, closes any open frame and
// clears the carry byte; nothing is presented until a new item arrives.
module aac_loas_latm_framer_unit #(
  parameter int MAX_AU_BYTES = aac_llf_pkg::MAX_AU_BYTES_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  aac_llf_in_if.sink     in_ch,
  aac_llf_out_if.source  out_ch
);
  import aac_llf_pkg::*;

  logic q_full;
  logic push;
  cmd_t push_cmd;
  logic pop;
  logic q_valid;
  cmd_t q_cmd;

  aac_llf_front #(.MAX_AU_BYTES(MAX_AU_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .q_full(q_full),
    .push(push), .push_cmd(push_cmd)
  );

  aac_llf_queue u_queue (
    .clk(clk), .rst_n(rst_n), .push(push), .push_cmd(push_cmd), .full(q_full),
    .pop(pop), .q_valid(q_valid), .q_cmd(q_cmd)
  );

  aac_llf_back u_back (
    .clk(clk), .rst_n(rst_n), .q_valid(q_valid), .q_cmd(q_cmd), .pop(pop),
    .out_ch(out_ch)
  );

endmodule

// File: rtl/aac_llf_chk.sv
module aac_llf_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       frame_end
);

  logic seen_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seen_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      seen_r <= 1'b1;
    end
  end

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("output valid dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_byte) && $stable(frame_end))
    else $error("output payload changed while stalled");

  a_reset_idle: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("output valid straight after reset");

  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> seen_r)
    else $error("output presented before any input transfer");

endmodule

bind aac_loas_latm_framer_unit aac_llf_chk u_chk (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_byte(out_ch.out_byte),
  .frame_end(out_ch.frame_end)
);
